>>> hdl/nearest_neighbor_scale_mapper_assert.svh
// Assertion macros shared by the scale mapper RTL.
`ifndef NEAREST_NEIGHBOR_SCALE_MAPPER_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_MAPPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NNSM_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("nnsm: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NNSM_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("nnsm: next-cycle check failed");

`endif

>>> hdl/nnsm_pkg.sv
// Shared constants and types of the nearest neighbor scale mapper.
package nnsm_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_BITS     = 16;
	localparam int STRIDE_BITS    = 18;
	localparam int PIXB_BITS      = 4;
	localparam int OFFSET_BITS    = 34;
	localparam int IN_DATA_BITS   = 32;
	localparam int OUT_DATA_BITS  = 72;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 18;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SRC_WIDTH   = 3'd0,
		REG_SRC_HEIGHT  = 3'd1,
		REG_RECT_WIDTH  = 3'd2,
		REG_RECT_HEIGHT = 3'd3,
		REG_RECT_LEFT   = 3'd4,
		REG_RECT_TOP    = 3'd5,
		REG_ROW_STRIDE  = 3'd6,
		REG_PIXEL_BYTES = 3'd7
	} cfg_reg_t;

	// Side information that rides along the divider chain untouched.
	typedef struct packed {
		logic                   oor;
		logic [OFFSET_BITS-1:0] prod_y;
		logic [OFFSET_BITS-1:0] prod_x;
	} nnsm_side_t;

endpackage

>>> hdl/nnsm_front.sv
// Front stages: bounds check, d*S products, dividends and byte offset products.
module nnsm_front #(
	parameter int COORD_BITS = nnsm_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [nnsm_pkg::FIELD_BITS-1:0]     col_offset,
	input  logic [nnsm_pkg::FIELD_BITS-1:0]     row_offset,
	input  logic [COORD_BITS-1:0]               sw_n,
	input  logic [COORD_BITS-1:0]               sh_n,
	input  logic [COORD_BITS-1:0]               rw_n,
	input  logic [COORD_BITS-1:0]               rh_n,
	input  logic [nnsm_pkg::FIELD_BITS-1:0]     rect_left,
	input  logic [nnsm_pkg::FIELD_BITS-1:0]     rect_top,
	input  logic [nnsm_pkg::STRIDE_BITS-1:0]    row_stride,
	input  logic [nnsm_pkg::PIXB_BITS-1:0]      pixel_bytes,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_BITS:0]                 rem_c,
	output logic [COORD_BITS-1:0]               low_c,
	output logic [COORD_BITS:0]                 rem_r,
	output logic [COORD_BITS-1:0]               low_r,
	output nnsm_pkg::nnsm_side_t                side
);
	import nnsm_pkg::*;

	localparam int N  = COORD_BITS;
	localparam int XW = ((N > FIELD_BITS) ? N : FIELD_BITS) + 1;
	localparam int YP = XW + STRIDE_BITS;
	localparam int XP = XW + PIXB_BITS;

	logic [N-1:0]     col_n, row_n;
	logic             oor_c;
	logic             v_s1, v_s2, rdy_s1, rdy_s2;
	logic [2*N-1:0]   mul_c_s1, mul_r_s1;
	logic             oor_s1;
	logic [XW-1:0]    xpos_s1, ypos_s1;
	logic [2*N+1:0]   num_c, num_r;
	logic [YP-1:0]    prod_y_full;
	logic [XP-1:0]    prod_x_full;
	logic [N:0]       rem_c_s2, rem_r_s2;
	logic [N-1:0]     low_c_s2, low_r_s2;
	nnsm_side_t       side_s2;

	assign col_n = N'(col_offset);
	assign row_n = N'(row_offset);
	// A zero-sized rectangle makes every offset compare as outside.
	assign oor_c = (col_n >= rw_n) || (row_n >= rh_n);

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			mul_c_s1 <= (2*N)'(col_n) * (2*N)'(sw_n);
			mul_r_s1 <= (2*N)'(row_n) * (2*N)'(sh_n);
			oor_s1   <= oor_c;
			xpos_s1  <= XW'(rect_left) + XW'(col_n);
			ypos_s1  <= XW'(rect_top) + XW'(row_n);
		end
	end

	// Dividend 2*d*S + R; its quotient by 2*R stays below 2^N inside the rectangle.
	assign num_c = (2*N+2)'({mul_c_s1, 1'b0}) + (2*N+2)'(rw_n);
	assign num_r = (2*N+2)'({mul_r_s1, 1'b0}) + (2*N+2)'(rh_n);
	assign prod_y_full = YP'(row_stride) * YP'(ypos_s1);
	assign prod_x_full = XP'(pixel_bytes) * XP'(xpos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			rem_c_s2       <= num_c[2*N:N];
			low_c_s2       <= num_c[N-1:0];
			rem_r_s2       <= num_r[2*N:N];
			low_r_s2       <= num_r[N-1:0];
			side_s2.oor    <= oor_s1;
			side_s2.prod_y <= prod_y_full[OFFSET_BITS-1:0];
			side_s2.prod_x <= OFFSET_BITS'(prod_x_full);
		end
	end

	assign out_valid = v_s2;
	assign rem_c     = rem_c_s2;
	assign low_c     = low_c_s2;
	assign rem_r     = rem_r_s2;
	assign low_r     = low_r_s2;
	assign side      = side_s2;

endmodule

>>> hdl/nnsm_div_cell.sv
// One divider cell: a restoring step for both axes that settles one quotient bit.
module nnsm_div_cell #(
	parameter int COORD_BITS = nnsm_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS:0]   den_c,
	input  logic [COORD_BITS:0]   den_r,
	input  logic [COORD_BITS:0]   rem_c_in,
	input  logic [COORD_BITS-1:0] low_c_in,
	input  logic [COORD_BITS-1:0] q_c_in,
	input  logic [COORD_BITS:0]   rem_r_in,
	input  logic [COORD_BITS-1:0] low_r_in,
	input  logic [COORD_BITS-1:0] q_r_in,
	input  nnsm_pkg::nnsm_side_t  side_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS:0]   rem_c_out,
	output logic [COORD_BITS-1:0] low_c_out,
	output logic [COORD_BITS-1:0] q_c_out,
	output logic [COORD_BITS:0]   rem_r_out,
	output logic [COORD_BITS-1:0] low_r_out,
	output logic [COORD_BITS-1:0] q_r_out,
	output nnsm_pkg::nnsm_side_t  side_out
);
	import nnsm_pkg::*;

	localparam int N = COORD_BITS;

	logic [N+1:0] t_c, t_r;
	logic         ge_c, ge_r;
	logic [N+1:0] d_c, d_r;
	logic         valid_q;
	logic [N:0]   rem_c_q, rem_r_q;
	logic [N-1:0] low_c_q, low_r_q, q_c_q, q_r_q;
	nnsm_side_t   side_q;

	// Bring down the next dividend bit and try the subtraction.
	assign t_c  = {rem_c_in, low_c_in[N-1]};
	assign t_r  = {rem_r_in, low_r_in[N-1]};
	assign ge_c = t_c >= (N+2)'(den_c);
	assign ge_r = t_r >= (N+2)'(den_r);
	assign d_c  = ge_c ? (t_c - (N+2)'(den_c)) : t_c;
	assign d_r  = ge_r ? (t_r - (N+2)'(den_r)) : t_r;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_c_q <= d_c[N:0];
			rem_r_q <= d_r[N:0];
			low_c_q <= {low_c_in[N-2:0], 1'b0};
			low_r_q <= {low_r_in[N-2:0], 1'b0};
			q_c_q   <= {q_c_in[N-2:0], ge_c};
			q_r_q   <= {q_r_in[N-2:0], ge_r};
			side_q  <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_c_out = rem_c_q;
	assign rem_r_out = rem_r_q;
	assign low_c_out = low_c_q;
	assign low_r_out = low_r_q;
	assign q_c_out   = q_c_q;
	assign q_r_out   = q_r_q;
	assign side_out  = side_q;

endmodule

>>> hdl/nnsm_out.sv
// Output stage: clamps the source indices, adds the byte offset, holds the result.
module nnsm_out #(
	parameter int COORD_BITS = nnsm_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             q_c,
	input  logic [COORD_BITS-1:0]             q_r,
	input  nnsm_pkg::nnsm_side_t              side,
	input  logic [COORD_BITS-1:0]             sw_n,
	input  logic [COORD_BITS-1:0]             sh_n,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nnsm_pkg::FIELD_BITS-1:0]   src_col,
	output logic [nnsm_pkg::FIELD_BITS-1:0]   src_row,
	output logic [nnsm_pkg::OFFSET_BITS-1:0]  dst_byte_offset,
	output logic                              out_of_rect
);
	import nnsm_pkg::*;

	localparam int N = COORD_BITS;

	logic [N-1:0]           idx_c, idx_r;
	logic [OFFSET_BITS-1:0] byte_sum;
	logic                   valid_q, oor_q;
	logic [FIELD_BITS-1:0]  col_q, row_q;
	logic [OFFSET_BITS-1:0] byte_q;

	// Rounding may land on S when upscaling; pull it back to S-1. S of zero gives 0.
	always_comb begin
		if (sw_n == '0) begin
			idx_c = '0;
		end else if (q_c >= sw_n) begin
			idx_c = sw_n - N'(1);
		end else begin
			idx_c = q_c;
		end
		if (sh_n == '0) begin
			idx_r = '0;
		end else if (q_r >= sh_n) begin
			idx_r = sh_n - N'(1);
		end else begin
			idx_r = q_r;
		end
	end

	assign byte_sum = side.prod_y + side.prod_x;
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			oor_q  <= side.oor;
			col_q  <= side.oor ? '0 : FIELD_BITS'(idx_c);
			row_q  <= side.oor ? '0 : FIELD_BITS'(idx_r);
			byte_q <= side.oor ? '0 : byte_sum;
		end
	end

	assign out_valid       = valid_q;
	assign src_col         = col_q;
	assign src_row         = row_q;
	assign dst_byte_offset = byte_q;
	assign out_of_rect     = oor_q;

endmodule

>>> hdl/nearest_neighbor_scale_mapper.sv
// Top level of the nearest neighbor scale mapper.
//
// Channel   Direction  Word contents (lowest bits first)
// s_*       in         tdata: col_offset[15:0], row_offset[15:0]
// m_*       out        tdata: src_col[15:0], src_row[15:0], dst_byte_offset[33:0], 6 zero bits
//                      tuser: out_of_rect
// cfg_*     in         write enable, register index, write data
//
// The block takes one word per clock cycle and delivers one result word per cycle
// while m_tready is high. The pipeline is two front stages, one divider cell per
// quotient bit (the row of cells sets the latency), and the output register.
// Reset clears all valid flags and loads the register defaults; no clearing pass.
// Each stage moves on when it is empty or the next stage takes its word, so a
// stalled output only stops the input once every stage holds a word.
module nearest_neighbor_scale_mapper #(
	parameter int COORD_BITS = nnsm_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [nnsm_pkg::IN_DATA_BITS-1:0]    s_tdata,  // col_offset, row_offset
	// Output stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [nnsm_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // src_col, src_row, dst_byte_offset, pad
	output logic                                 m_tuser,  // out_of_rect
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [nnsm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [nnsm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import nnsm_pkg::*;

	localparam int N = COORD_BITS;

	// Configuration registers, kept at their architectural widths.
	logic [FIELD_BITS-1:0]  src_width_q, src_height_q, rect_width_q, rect_height_q;
	logic [FIELD_BITS-1:0]  rect_left_q, rect_top_q;
	logic [STRIDE_BITS-1:0] row_stride_q;
	logic [PIXB_BITS-1:0]   pixel_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= FIELD_BITS'(1);
			src_height_q  <= FIELD_BITS'(1);
			rect_width_q  <= FIELD_BITS'(1);
			rect_height_q <= FIELD_BITS'(1);
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			row_stride_q  <= '0;
			pixel_bytes_q <= PIXB_BITS'(4);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:   src_width_q   <= cfg_data[FIELD_BITS-1:0];
				REG_SRC_HEIGHT:  src_height_q  <= cfg_data[FIELD_BITS-1:0];
				REG_RECT_WIDTH:  rect_width_q  <= cfg_data[FIELD_BITS-1:0];
				REG_RECT_HEIGHT: rect_height_q <= cfg_data[FIELD_BITS-1:0];
				REG_RECT_LEFT:   rect_left_q   <= cfg_data[FIELD_BITS-1:0];
				REG_RECT_TOP:    rect_top_q    <= cfg_data[FIELD_BITS-1:0];
				REG_ROW_STRIDE:  row_stride_q  <= cfg_data[STRIDE_BITS-1:0];
				REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[PIXB_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sizes seen at the coordinate width of the datapath.
	logic [N-1:0] sw_n, sh_n, rw_n, rh_n;
	logic [N:0]   den_c, den_r;

	assign sw_n  = N'(src_width_q);
	assign sh_n  = N'(src_height_q);
	assign rw_n  = N'(rect_width_q);
	assign rh_n  = N'(rect_height_q);
	// The divisor of the rounded quotient is twice the rectangle size.
	assign den_c = {rw_n, 1'b0};
	assign den_r = {rh_n, 1'b0};

	// Chain links: index 0 is the front output, index N feeds the output stage.
	logic             lv    [0:N];
	logic             lr    [0:N];
	logic [N:0]       lrem_c[0:N];
	logic [N-1:0]     llow_c[0:N];
	logic [N-1:0]     lq_c  [0:N];
	logic [N:0]       lrem_r[0:N];
	logic [N-1:0]     llow_r[0:N];
	logic [N-1:0]     lq_r  [0:N];
	nnsm_side_t       lside [0:N];

	nnsm_front #(
		.COORD_BITS(N)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.col_offset  (s_tdata[FIELD_BITS-1:0]),
		.row_offset  (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
		.sw_n        (sw_n),
		.sh_n        (sh_n),
		.rw_n        (rw_n),
		.rh_n        (rh_n),
		.rect_left   (rect_left_q),
		.rect_top    (rect_top_q),
		.row_stride  (row_stride_q),
		.pixel_bytes (pixel_bytes_q),
		.out_valid   (lv[0]),
		.out_ready   (lr[0]),
		.rem_c       (lrem_c[0]),
		.low_c       (llow_c[0]),
		.rem_r       (lrem_r[0]),
		.low_r       (llow_r[0]),
		.side        (lside[0])
	);

	// The quotient shift registers start empty.
	assign lq_c[0] = '0;
	assign lq_r[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		nnsm_div_cell #(
			.COORD_BITS(N)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lv[k]),
			.in_ready  (lr[k]),
			.den_c     (den_c),
			.den_r     (den_r),
			.rem_c_in  (lrem_c[k]),
			.low_c_in  (llow_c[k]),
			.q_c_in    (lq_c[k]),
			.rem_r_in  (lrem_r[k]),
			.low_r_in  (llow_r[k]),
			.q_r_in    (lq_r[k]),
			.side_in   (lside[k]),
			.out_valid (lv[k+1]),
			.out_ready (lr[k+1]),
			.rem_c_out (lrem_c[k+1]),
			.low_c_out (llow_c[k+1]),
			.q_c_out   (lq_c[k+1]),
			.rem_r_out (lrem_r[k+1]),
			.low_r_out (llow_r[k+1]),
			.q_r_out   (lq_r[k+1]),
			.side_out  (lside[k+1])
		);
	end

	logic [FIELD_BITS-1:0]  src_col, src_row;
	logic [OFFSET_BITS-1:0] dst_byte_offset;
	logic                   out_of_rect;

	nnsm_out #(
		.COORD_BITS(N)
	) u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (lv[N]),
		.in_ready        (lr[N]),
		.q_c             (lq_c[N]),
		.q_r             (lq_r[N]),
		.side            (lside[N]),
		.sw_n            (sw_n),
		.sh_n            (sh_n),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.src_col         (src_col),
		.src_row         (src_row),
		.dst_byte_offset (dst_byte_offset),
		.out_of_rect     (out_of_rect)
	);

	// The remainders leave the last cell unused; only the quotients matter there.
	assign m_tdata = {(OUT_DATA_BITS - OFFSET_BITS - 2*FIELD_BITS)'(0),
		dst_byte_offset, src_row, src_col};
	assign m_tuser = out_of_rect;

`include "nearest_neighbor_scale_mapper_assert.svh"

	// The input side can only stall when the output holds a word nobody takes.
	`NNSM_ASSERT_IMPLY(a_stall_needs_word, clk, arst_n, !s_tready, m_tvalid)
	`NNSM_ASSERT_IMPLY(a_stall_needs_backpressure, clk, arst_n, !s_tready, !m_tready)
	// An offset outside the rectangle yields all-zero result fields.
	`NNSM_ASSERT_IMPLY(a_oor_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	// A pixel size write lands in the register on the next edge.
	`NNSM_ASSERT_NEXT(a_cfg_pixb, clk, arst_n, cfg_we && (cfg_index == REG_PIXEL_BYTES), pixel_bytes_q == $past(cfg_data[PIXB_BITS-1:0]))

endmodule
